[rtl/aabb_frustum_cull_defines.svh]
// assertion macros for the culling block
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// same-cycle implication, off during reset
`define AFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afc check failed");

// next-cycle implication, also watched across reset
`define AFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("afc check failed");

`endif

[rtl/afc_pkg.sv]
package afc_pkg;

  localparam int NUM_PLANES_DEF  = 6;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_REGS        = 6;
  localparam int REG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int COMP_W          = 16;
  localparam int D_SHIFT         = 14;
  localparam int RES_W           = 2;

  localparam logic [RES_W-1:0] RES_INSIDE    = 2'd0;
  localparam logic [RES_W-1:0] RES_INTERSECT = 2'd1;
  localparam logic [RES_W-1:0] RES_OUTSIDE   = 2'd2;

  typedef logic [REG_W-1:0] plane_t;
  typedef logic [RES_W-1:0] res_t;

endpackage

[rtl/afc_box_if.sv]
interface afc_box_if import afc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;

  modport source (output valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z,
                box_max_x, box_max_y, box_max_z, output ready);
endinterface

[rtl/afc_result_if.sv]
interface afc_result_if import afc_pkg::*;;
  logic valid;
  logic ready;
  res_t cull_result;

  modport source (output valid, cull_result, input ready);
  modport sink (input valid, cull_result, output ready);
endinterface

[rtl/aabb_frustum_cull.sv]
// a box goes from request to result through the plane cells in order
// throughput: one box per cycle while result.ready is high, two register stages per plane cell
// rst clears all stage valid bits and sets every plane register to zero
// with zero planes every box reads as inside
module aabb_frustum_cull import afc_pkg::*; #(
  parameter int NUM_PLANES  = NUM_PLANES_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  afc_box_if.sink              box,
  afc_result_if.source         result,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

`include "aabb_frustum_cull_defines.svh"

  plane_t                      planes [NUM_REGS];
  logic                        chain_v [NUM_PLANES+1];
  logic                        chain_r [NUM_PLANES+1];
  logic [2:0][COORD_WIDTH-1:0] chain_lo [NUM_PLANES+1];
  logic [2:0][COORD_WIDTH-1:0] chain_hi [NUM_PLANES+1];
  res_t                        chain_res [NUM_PLANES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        planes[i] <= '0;
      end
    end else if (cfg_wr_en && (int'(cfg_index) < NUM_REGS)) begin
      planes[cfg_index] <= cfg_data;
    end
  end

  assign chain_v[0]   = box.valid;
  assign box.ready    = chain_r[0];
  assign chain_lo[0]  = {box.box_min_z, box.box_min_y, box.box_min_x};
  assign chain_hi[0]  = {box.box_max_z, box.box_max_y, box.box_max_x};
  assign chain_res[0] = RES_INSIDE;

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    afc_cell #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .plane     (planes[i]),
      .in_valid  (chain_v[i]),
      .in_ready  (chain_r[i]),
      .in_lo     (chain_lo[i]),
      .in_hi     (chain_hi[i]),
      .in_res    (chain_res[i]),
      .out_valid (chain_v[i+1]),
      .out_ready (chain_r[i+1]),
      .out_lo    (chain_lo[i+1]),
      .out_hi    (chain_hi[i+1]),
      .out_res   (chain_res[i+1])
    );
  end

  assign result.valid       = chain_v[NUM_PLANES];
  assign result.cull_result = chain_res[NUM_PLANES];
  assign chain_r[NUM_PLANES] = result.ready;

  `AFC_ASSERT_IMP(a_ready_chain, result.ready, box.ready)
  `AFC_ASSERT_NXT(a_reset_empty, rst, !result.valid)
  `AFC_ASSERT_IMP(a_res_code, result.valid,
    result.cull_result == RES_INSIDE || result.cull_result == RES_INTERSECT ||
    result.cull_result == RES_OUTSIDE)

endmodule

[rtl/afc_cell.sv]
module afc_cell import afc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  plane_t                      plane,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0][COORD_WIDTH-1:0] in_lo,
  input  logic [2:0][COORD_WIDTH-1:0] in_hi,
  input  res_t                        in_res,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0][COORD_WIDTH-1:0] out_lo,
  output logic [2:0][COORD_WIDTH-1:0] out_hi,
  output res_t                        out_res
);

  localparam int PW = COORD_WIDTH + COMP_W;
  localparam int DW = COMP_W + D_SHIFT;
  localparam int SW = ((PW > DW) ? PW : DW) + 2;

  logic signed [COMP_W-1:0]      nrm [3];
  logic                          neg [3];
  logic signed [COORD_WIDTH-1:0] pv [3];
  logic signed [COORD_WIDTH-1:0] nv [3];
  logic signed [PW-1:0]          pp_next [3];
  logic signed [PW-1:0]          np_next [3];
  logic signed [COMP_W-1:0]      d;

  // multiply stage
  logic                          v1;
  logic [2:0][COORD_WIDTH-1:0]   lo1;
  logic [2:0][COORD_WIDTH-1:0]   hi1;
  res_t                          res1;
  logic signed [PW-1:0]          pp [3];
  logic signed [PW-1:0]          np [3];
  logic                          ready1;
  logic                          ready2;

  // sum stage
  logic signed [SW-1:0]          dist_p;
  logic signed [SW-1:0]          dist_n;
  res_t                          res_local;
  res_t                          res_next;

  assign d = signed'(plane[3*COMP_W +: COMP_W]);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nrm[a]     = signed'(plane[COMP_W*a +: COMP_W]);
      neg[a]     = plane[COMP_W*a + COMP_W - 1];
      pv[a]      = neg[a] ? signed'(in_lo[a]) : signed'(in_hi[a]);
      nv[a]      = neg[a] ? signed'(in_hi[a]) : signed'(in_lo[a]);
      pp_next[a] = PW'(nrm[a]) * PW'(pv[a]);
      np_next[a] = PW'(nrm[a]) * PW'(nv[a]);
    end
  end

  assign ready2   = !out_valid || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
    if (ready1 && in_valid) begin
      lo1  <= in_lo;
      hi1  <= in_hi;
      res1 <= in_res;
      for (int a = 0; a < 3; a++) begin
        pp[a] <= pp_next[a];
        np[a] <= np_next[a];
      end
    end
  end

  always_comb begin
    dist_p = SW'(pp[0]) + SW'(pp[1]) + SW'(pp[2]) + (SW'(d) <<< D_SHIFT);
    dist_n = SW'(np[0]) + SW'(np[1]) + SW'(np[2]) + (SW'(d) <<< D_SHIFT);
    if (dist_p[SW-1]) begin
      res_local = RES_OUTSIDE;
    end else if (dist_n[SW-1]) begin
      res_local = RES_INTERSECT;
    end else begin
      res_local = RES_INSIDE;
    end
    // outside outranks intersect outranks inside
    res_next = (res_local > res1) ? res_local : res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
    if (ready2 && v1) begin
      out_lo  <= lo1;
      out_hi  <= hi1;
      out_res <= res_next;
    end
  end

endmodule
